>>> design/kfpv_pkg.sv
// Shared types, constants and saturation helpers for the two-state Kalman filter.
// Used by every module of the block; depends on nothing.
package kfpv_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int DT_W      = 24;
  localparam int MEAS_W    = 16;
  localparam int GAIN_W    = FRAC_BITS + 1;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int MRES_W    = PROD_W - FRAC_BITS + 1;  // signed rounded product
  localparam int SUM_W     = MRES_W + 1;
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 3;
  localparam int CNT_W      = $clog2(FRAC_BITS);

  localparam logic [GAIN_W-1:0] ONE = GAIN_W'(1) << FRAC_BITS;

  localparam logic signed [SUM_W-1:0] SMAX =
    {{(SUM_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SMIN =
    {{(SUM_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
  localparam logic signed [SUM_W-1:0] UMAX =
    {{(SUM_W-DATA_W){1'b0}}, {DATA_W{1'b1}}};

  localparam logic [DATA_W-1:0] RST_INIT_POS  = 32'd262144000;
  localparam logic [DATA_W-1:0] RST_INIT_VEL  = 32'd18350080;
  localparam logic [DATA_W-1:0] RST_INIT_PVAR = 32'd26214400;
  localparam logic [DATA_W-1:0] RST_INIT_VVAR = 32'd1638400;
  localparam logic [DATA_W-1:0] RST_POS_NOISE = 32'd40960000;
  localparam logic [DATA_W-1:0] RST_VEL_NOISE = 32'd2359296;
  localparam logic [DT_W-1:0]   RST_TIME_STEP = 24'd65536;
  localparam logic [DATA_W-1:0] RST_ACCEL     = 32'd131072;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_INIT_POS,
    REG_INIT_VEL,
    REG_INIT_PVAR,
    REG_INIT_VVAR,
    REG_POS_NOISE,
    REG_VEL_NOISE,
    REG_TIME_STEP,
    REG_ACCEL
  } kfpv_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_WB,
    ST_SUMX,
    ST_DIV,
    ST_DWAIT,
    ST_DONE
  } kfpv_state_t;

  typedef enum logic [3:0] {
    OP_DT2,
    OP_DT2H,
    OP_M1,
    OP_M2,
    OP_M3,
    OP_PVP,
    OP_CORR,
    OP_T1A,
    OP_T1B,
    OP_T2A,
    OP_T2B
  } kfpv_op_t;

  typedef struct packed {
    logic [DATA_W-1:0] init_position;
    logic [DATA_W-1:0] init_velocity;
    logic [DATA_W-1:0] init_position_variance;
    logic [DATA_W-1:0] init_velocity_variance;
    logic [DATA_W-1:0] position_noise;
    logic [DATA_W-1:0] velocity_noise;
    logic [DT_W-1:0]   time_step;
    logic [DATA_W-1:0] acceleration;
  } kfpv_cfg_t;

  typedef struct packed {
    logic              start;
    logic              neg;
    logic              half;   // shift by FRAC_BITS+1 instead of FRAC_BITS
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } kfpv_mul_req_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] p;
    logic [DATA_W-1:0] r;
  } kfpv_div_req_t;

  typedef struct packed {
    logic              done;
    logic [GAIN_W-1:0] q;
  } kfpv_div_rsp_t;

  typedef struct packed {
    logic [DATA_W-1:0] est_position;
    logic [DATA_W-1:0] est_velocity;
    logic [DATA_W-1:0] position_var;
    logic [DATA_W-1:0] velocity_var;
    logic [GAIN_W-1:0] position_gain;
    logic [GAIN_W-1:0] velocity_gain;
    logic              saturated;
  } kfpv_result_t;

  typedef struct packed {
    logic              clip;
    logic [DATA_W-1:0] value;
  } kfpv_sat_t;

  function automatic kfpv_sat_t sat_s(input logic signed [SUM_W-1:0] v);
    kfpv_sat_t r;
    r.clip  = 1'b0;
    r.value = v[DATA_W-1:0];
    if (v > SMAX) begin
      r.clip  = 1'b1;
      r.value = SMAX[DATA_W-1:0];
    end else if (v < SMIN) begin
      r.clip  = 1'b1;
      r.value = SMIN[DATA_W-1:0];
    end
    return r;
  endfunction

  // caller passes a non-negative value
  function automatic kfpv_sat_t sat_u(input logic signed [SUM_W-1:0] v);
    kfpv_sat_t r;
    r.clip  = 1'b0;
    r.value = v[DATA_W-1:0];
    if (v > UMAX) begin
      r.clip  = 1'b1;
      r.value = UMAX[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> design/kfpv_if.sv
// Valid/ready channel interfaces: measurement requests in, estimate results out.
// Depends on kfpv_pkg for field widths.
interface kfpv_meas_if;
  logic                                valid;
  logic                                ready;
  logic                                restart;
  logic signed [kfpv_pkg::MEAS_W-1:0]  position_meas;
  logic signed [kfpv_pkg::MEAS_W-1:0]  velocity_meas;

  modport source(output valid, restart, position_meas, velocity_meas, input ready);
  modport sink(input valid, restart, position_meas, velocity_meas, output ready);
endinterface

interface kfpv_est_if;
  logic                                valid;
  logic                                ready;
  logic signed [kfpv_pkg::DATA_W-1:0]  est_position;
  logic signed [kfpv_pkg::DATA_W-1:0]  est_velocity;
  logic [kfpv_pkg::DATA_W-1:0]         position_var;
  logic [kfpv_pkg::DATA_W-1:0]         velocity_var;
  logic [kfpv_pkg::GAIN_W-1:0]         position_gain;
  logic [kfpv_pkg::GAIN_W-1:0]         velocity_gain;
  logic                                saturated;

  modport source(output valid, est_position, est_velocity, position_var, velocity_var,
                 position_gain, velocity_gain, saturated, input ready);
  modport sink(input valid, est_position, est_velocity, position_var, velocity_var,
               position_gain, velocity_gain, saturated, output ready);
endinterface

>>> design/kfpv_regs.sv
// APB configuration register file of the Kalman filter.
// Depends on kfpv_pkg for the register map and the config struct.
module kfpv_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [kfpv_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [kfpv_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [kfpv_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready,
  output kfpv_pkg::kfpv_cfg_t                  cfg
);

  kfpv_pkg::kfpv_reg_e idx;
  logic                wr;

  assign idx    = kfpv_pkg::kfpv_reg_e'(paddr[kfpv_pkg::APB_ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.init_position          <= kfpv_pkg::RST_INIT_POS;
      cfg.init_velocity          <= kfpv_pkg::RST_INIT_VEL;
      cfg.init_position_variance <= kfpv_pkg::RST_INIT_PVAR;
      cfg.init_velocity_variance <= kfpv_pkg::RST_INIT_VVAR;
      cfg.position_noise         <= kfpv_pkg::RST_POS_NOISE;
      cfg.velocity_noise         <= kfpv_pkg::RST_VEL_NOISE;
      cfg.time_step              <= kfpv_pkg::RST_TIME_STEP;
      cfg.acceleration           <= kfpv_pkg::RST_ACCEL;
    end else if (wr) begin
      case (idx)
        kfpv_pkg::REG_INIT_POS:  cfg.init_position          <= pwdata;
        kfpv_pkg::REG_INIT_VEL:  cfg.init_velocity          <= pwdata;
        kfpv_pkg::REG_INIT_PVAR: cfg.init_position_variance <= pwdata;
        kfpv_pkg::REG_INIT_VVAR: cfg.init_velocity_variance <= pwdata;
        kfpv_pkg::REG_POS_NOISE: cfg.position_noise         <= pwdata;
        kfpv_pkg::REG_VEL_NOISE: cfg.velocity_noise         <= pwdata;
        kfpv_pkg::REG_TIME_STEP: cfg.time_step              <= pwdata[kfpv_pkg::DT_W-1:0];
        kfpv_pkg::REG_ACCEL:     cfg.acceleration           <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      kfpv_pkg::REG_INIT_POS:  prdata = cfg.init_position;
      kfpv_pkg::REG_INIT_VEL:  prdata = cfg.init_velocity;
      kfpv_pkg::REG_INIT_PVAR: prdata = cfg.init_position_variance;
      kfpv_pkg::REG_INIT_VVAR: prdata = cfg.init_velocity_variance;
      kfpv_pkg::REG_POS_NOISE: prdata = cfg.position_noise;
      kfpv_pkg::REG_VEL_NOISE: prdata = cfg.velocity_noise;
      kfpv_pkg::REG_TIME_STEP: prdata = kfpv_pkg::APB_DATA_W'(cfg.time_step);
      kfpv_pkg::REG_ACCEL:     prdata = cfg.acceleration;
      default:                 prdata = '0;
    endcase
  end

endmodule

>>> design/kfpv_mul.sv
// Shared 32x32 magnitude multiplier with registered product and round-half-away shift.
// Depends on kfpv_pkg for the request struct and widths.
module kfpv_mul (
  input  logic                                  clk,
  input  kfpv_pkg::kfpv_mul_req_t               req,
  output logic signed [kfpv_pkg::MRES_W-1:0]    res
);

  localparam int PW = kfpv_pkg::PROD_W;
  localparam int FB = kfpv_pkg::FRAC_BITS;
  localparam int MW = kfpv_pkg::MRES_W - 1;

  logic [PW-1:0]                      prod;
  logic                               neg;
  logic                               half;
  logic [MW-1:0]                      mag;
  logic signed [kfpv_pkg::MRES_W-1:0] smag;

  always_ff @(posedge clk) begin
    if (req.start) begin
      prod <= PW'(req.a) * PW'(req.b);
      neg  <= req.neg;
      half <= req.half;
    end
  end

  // rounding adds the first dropped bit; magnitudes stay well below the word
  always_comb begin
    if (half) begin
      mag = MW'(prod[PW-1:FB+1]) + MW'(prod[FB]);
    end else begin
      mag = prod[PW-1:FB] + MW'(prod[FB-1]);
    end
    smag = $signed({1'b0, mag});
    res  = neg ? -smag : smag;
  end

endmodule

>>> design/kfpv_div.sv
// Radix-2 restoring divider for the gain p/(p+r), one quotient bit per cycle.
// Depends on kfpv_pkg for the request and response structs.
module kfpv_div (
  input  logic                     clk,
  input  logic                     rst,
  input  kfpv_pkg::kfpv_div_req_t  req,
  output kfpv_pkg::kfpv_div_rsp_t  rsp
);

  localparam int DW = kfpv_pkg::DATA_W + 1;
  localparam int FB = kfpv_pkg::FRAC_BITS;
  localparam int CW = kfpv_pkg::CNT_W;

  logic                        busy;
  logic                        done;
  logic [CW-1:0]               cnt;
  logic [DW-1:0]               den;
  logic [DW-1:0]               rem;
  logic [FB-1:0]               quo;
  logic [kfpv_pkg::GAIN_W-1:0] q_out;
  logic [DW-1:0]               sum;
  logic [DW:0]                 shifted;
  logic                        fits;
  logic [DW-1:0]               rem_next;
  logic [FB-1:0]               quo_next;

  assign sum      = DW'(req.p) + DW'(req.r);
  assign shifted  = {rem, 1'b0};
  assign fits     = shifted >= {1'b0, den};
  assign rem_next = fits ? DW'(shifted - {1'b0, den}) : shifted[DW-1:0];
  assign quo_next = {quo[FB-2:0], fits};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        // zero denominator gives zero gain, zero noise a gain of one
        if (sum == '0 || req.r == '0) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      den   <= sum;
      rem   <= DW'(req.p);
      quo   <= '0;
      cnt   <= CW'(FB - 1);
      q_out <= (sum == '0) ? '0 : kfpv_pkg::ONE;
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
      cnt <= cnt - CW'(1);
      if (cnt == '0) begin
        q_out <= {1'b0, quo_next};
      end
    end
  end

  assign rsp.done = done;
  assign rsp.q    = q_out;

endmodule

>>> design/kfpv_core.sv
// Sequencer and state registers of the filter; runs every product through kfpv_mul
// and both gains through kfpv_div. Depends on kfpv_pkg, kfpv_if, kfpv_mul, kfpv_div.
module kfpv_core (
  input  logic                     clk,
  input  logic                     rst,
  input  kfpv_pkg::kfpv_cfg_t      cfg,
  kfpv_meas_if.sink                meas,
  input  logic                     res_free,
  output logic                     res_load,
  output kfpv_pkg::kfpv_result_t   res
);

  localparam int DW = kfpv_pkg::DATA_W;
  localparam int SW = kfpv_pkg::SUM_W;
  localparam int GW = kfpv_pkg::GAIN_W;
  localparam int MW = kfpv_pkg::MEAS_W;
  localparam int FB = kfpv_pkg::FRAC_BITS;
  localparam int IW = DW + 2;

  kfpv_pkg::kfpv_state_t state, state_next;
  kfpv_pkg::kfpv_op_t    op, op_next;
  logic                  axis, axis_next;

  logic signed [DW-1:0] x0, x1, m1, m2, m3;
  logic [DW-1:0]        p0, p1, dt2, dt2h, t1, t2;
  logic [GW-1:0]        k, k0, k1;
  logic signed [MW-1:0] meas0, meas1;
  logic                 flag;

  kfpv_pkg::kfpv_mul_req_t          mul_req;
  kfpv_pkg::kfpv_div_req_t          div_req;
  kfpv_pkg::kfpv_div_rsp_t          div_rsp;
  logic signed [kfpv_pkg::MRES_W-1:0] mres;
  logic signed [SW-1:0]             mwide;

  logic signed [DW-1:0] xa;
  logic [DW-1:0]        pa, ra;
  logic signed [MW-1:0] measa;
  logic signed [IW-1:0] innov, innov_neg;
  logic [DW-1:0]        innov_mag;
  logic [DW-1:0]        acc_mag, vel_mag, acc_neg, vel_neg;
  logic [GW-1:0]        om;
  logic                 accept;

  kfpv_pkg::kfpv_sat_t sat_res_u, sat_res_s, sat_pvp, sat_corr, sat_pnew, sat_x0, sat_x1;

  kfpv_mul u_mul (
    .clk (clk),
    .req (mul_req),
    .res (mres)
  );

  kfpv_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign accept = meas.valid && meas.ready;

  // per-axis operand selection
  assign xa    = axis ? x1 : x0;
  assign pa    = axis ? p1 : p0;
  assign ra    = axis ? cfg.velocity_noise : cfg.position_noise;
  assign measa = axis ? meas1 : meas0;

  assign innov     = $signed({{2{measa[MW-1]}}, measa, {FB{1'b0}}}) - IW'(xa);
  assign innov_neg = -innov;
  assign innov_mag = innov[IW-1] ? innov_neg[DW-1:0] : innov[DW-1:0];
  assign acc_neg   = -cfg.acceleration;
  assign acc_mag   = cfg.acceleration[DW-1] ? acc_neg : cfg.acceleration;
  assign vel_neg   = -x1;
  assign vel_mag   = x1[DW-1] ? vel_neg : x1;
  assign om        = kfpv_pkg::ONE - k;

  assign mwide     = SW'(mres);
  assign sat_res_u = kfpv_pkg::sat_u(mwide);
  assign sat_res_s = kfpv_pkg::sat_s(mwide);
  assign sat_pvp   = kfpv_pkg::sat_u(SW'({1'b0, p0}) + mwide);
  assign sat_corr  = kfpv_pkg::sat_s(SW'(xa) + mwide);
  assign sat_pnew  = kfpv_pkg::sat_u(SW'({1'b0, t2}) + SW'({1'b0, sat_res_u.value}));
  assign sat_x0    = kfpv_pkg::sat_s(SW'(x0) + SW'(m1) + SW'(m2));
  assign sat_x1    = kfpv_pkg::sat_s(SW'(x1) + SW'(m3));

  // next state
  always_comb begin
    state_next = state;
    op_next    = op;
    axis_next  = axis;
    case (state)
      kfpv_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = kfpv_pkg::ST_MUL;
          op_next    = kfpv_pkg::OP_DT2;
          axis_next  = 1'b0;
        end
      end
      kfpv_pkg::ST_MUL: state_next = kfpv_pkg::ST_WB;
      kfpv_pkg::ST_WB: begin
        state_next = kfpv_pkg::ST_MUL;
        case (op)
          kfpv_pkg::OP_DT2:  op_next = kfpv_pkg::OP_DT2H;
          kfpv_pkg::OP_DT2H: op_next = kfpv_pkg::OP_M1;
          kfpv_pkg::OP_M1:   op_next = kfpv_pkg::OP_M2;
          kfpv_pkg::OP_M2:   op_next = kfpv_pkg::OP_M3;
          kfpv_pkg::OP_M3:   state_next = kfpv_pkg::ST_SUMX;
          kfpv_pkg::OP_PVP:  state_next = kfpv_pkg::ST_DIV;
          kfpv_pkg::OP_CORR: op_next = kfpv_pkg::OP_T1A;
          kfpv_pkg::OP_T1A:  op_next = kfpv_pkg::OP_T1B;
          kfpv_pkg::OP_T1B:  op_next = kfpv_pkg::OP_T2A;
          kfpv_pkg::OP_T2A:  op_next = kfpv_pkg::OP_T2B;
          kfpv_pkg::OP_T2B: begin
            if (!axis) begin
              axis_next  = 1'b1;
              state_next = kfpv_pkg::ST_DIV;
            end else begin
              state_next = kfpv_pkg::ST_DONE;
            end
          end
          default: state_next = kfpv_pkg::ST_IDLE;
        endcase
      end
      kfpv_pkg::ST_SUMX: begin
        op_next    = kfpv_pkg::OP_PVP;
        state_next = kfpv_pkg::ST_MUL;
      end
      kfpv_pkg::ST_DIV: state_next = kfpv_pkg::ST_DWAIT;
      kfpv_pkg::ST_DWAIT: begin
        if (div_rsp.done) begin
          op_next    = kfpv_pkg::OP_CORR;
          state_next = kfpv_pkg::ST_MUL;
        end
      end
      kfpv_pkg::ST_DONE: begin
        if (res_free) begin
          state_next = kfpv_pkg::ST_IDLE;
        end
      end
      default: state_next = kfpv_pkg::ST_IDLE;
    endcase
  end

  // outputs and unit operands
  always_comb begin
    meas.ready    = (state == kfpv_pkg::ST_IDLE);
    res_load      = (state == kfpv_pkg::ST_DONE) && res_free;
    div_req.start = (state == kfpv_pkg::ST_DIV);
    div_req.p     = pa;
    div_req.r     = ra;
    mul_req.start = (state == kfpv_pkg::ST_MUL);
    mul_req.neg   = 1'b0;
    mul_req.half  = 1'b0;
    mul_req.a     = DW'(cfg.time_step);
    mul_req.b     = DW'(cfg.time_step);
    case (op)
      kfpv_pkg::OP_DT2: ;
      kfpv_pkg::OP_DT2H: mul_req.half = 1'b1;
      kfpv_pkg::OP_M1: begin
        mul_req.b   = vel_mag;
        mul_req.neg = x1[DW-1];
      end
      kfpv_pkg::OP_M2: begin
        mul_req.a   = dt2h;
        mul_req.b   = acc_mag;
        mul_req.neg = cfg.acceleration[DW-1];
      end
      kfpv_pkg::OP_M3: begin
        mul_req.b   = acc_mag;
        mul_req.neg = cfg.acceleration[DW-1];
      end
      kfpv_pkg::OP_PVP: begin
        mul_req.a = dt2;
        mul_req.b = p1;
      end
      kfpv_pkg::OP_CORR: begin
        mul_req.a   = DW'(k);
        mul_req.b   = innov_mag;
        mul_req.neg = innov[IW-1];
      end
      kfpv_pkg::OP_T1A: begin
        mul_req.a = pa;
        mul_req.b = DW'(om);
      end
      kfpv_pkg::OP_T1B: begin
        mul_req.a = t1;
        mul_req.b = DW'(om);
      end
      kfpv_pkg::OP_T2A: begin
        mul_req.a = DW'(k);
        mul_req.b = ra;
      end
      kfpv_pkg::OP_T2B: begin
        mul_req.a = t1;   // t1 slot is reused for k*r here
        mul_req.b = DW'(k);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kfpv_pkg::ST_IDLE;
      op    <= kfpv_pkg::OP_DT2;
      axis  <= 1'b0;
    end else begin
      state <= state_next;
      op    <= op_next;
      axis  <= axis_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x0 <= '0;
      x1 <= '0;
      p0 <= '0;
      p1 <= '0;
    end else begin
      case (state)
        kfpv_pkg::ST_IDLE: begin
          if (accept) begin
            meas0 <= meas.position_meas;
            meas1 <= meas.velocity_meas;
            flag  <= 1'b0;
            if (meas.restart) begin
              x0 <= $signed(cfg.init_position);
              x1 <= $signed(cfg.init_velocity);
              p0 <= cfg.init_position_variance;
              p1 <= cfg.init_velocity_variance;
            end
          end
        end
        kfpv_pkg::ST_SUMX: begin
          x0   <= $signed(sat_x0.value);
          x1   <= $signed(sat_x1.value);
          flag <= flag | sat_x0.clip | sat_x1.clip;
        end
        kfpv_pkg::ST_DWAIT: begin
          if (div_rsp.done) begin
            k <= div_rsp.q;
            if (axis) begin
              k1 <= div_rsp.q;
            end else begin
              k0 <= div_rsp.q;
            end
          end
        end
        kfpv_pkg::ST_WB: begin
          case (op)
            kfpv_pkg::OP_DT2: begin
              dt2  <= sat_res_u.value;
              flag <= flag | sat_res_u.clip;
            end
            kfpv_pkg::OP_DT2H: begin
              dt2h <= sat_res_u.value;
              flag <= flag | sat_res_u.clip;
            end
            kfpv_pkg::OP_M1: begin
              m1   <= $signed(sat_res_s.value);
              flag <= flag | sat_res_s.clip;
            end
            kfpv_pkg::OP_M2: begin
              m2   <= $signed(sat_res_s.value);
              flag <= flag | sat_res_s.clip;
            end
            kfpv_pkg::OP_M3: begin
              m3   <= $signed(sat_res_s.value);
              flag <= flag | sat_res_s.clip;
            end
            kfpv_pkg::OP_PVP: begin
              p0   <= sat_pvp.value;
              flag <= flag | sat_pvp.clip;
            end
            kfpv_pkg::OP_CORR: begin
              if (axis) begin
                x1 <= $signed(sat_corr.value);
              end else begin
                x0 <= $signed(sat_corr.value);
              end
              flag <= flag | sat_corr.clip;
            end
            kfpv_pkg::OP_T1A, kfpv_pkg::OP_T1B: begin
              t1   <= sat_res_u.value;
              flag <= flag | sat_res_u.clip;
            end
            kfpv_pkg::OP_T2A: begin
              // p(1-k)^2 parks in t2 while t1 carries k*r into the last product
              t2   <= t1;
              t1   <= sat_res_u.value;
              flag <= flag | sat_res_u.clip;
            end
            kfpv_pkg::OP_T2B: begin
              if (axis) begin
                p1 <= sat_pnew.value;
              end else begin
                p0 <= sat_pnew.value;
              end
              flag <= flag | sat_res_u.clip | sat_pnew.clip;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  assign res.est_position  = x0;
  assign res.est_velocity  = x1;
  assign res.position_var  = p0;
  assign res.velocity_var  = p1;
  assign res.position_gain = k0;
  assign res.velocity_gain = k1;
  assign res.saturated     = flag;

endmodule

>>> design/kalman_filter_pos_vel_2state_top.sv
// Top level of the two-state position/velocity Kalman filter: APB registers,
// the sequenced core and the result register. Depends on kfpv_pkg, kfpv_if,
// kfpv_regs and kfpv_core.
//
// Usage: a request on the meas channel carries restart, position_meas and
// velocity_meas; each request yields exactly one result on the est channel.
// meas.ready is high only while the core is idle. An accepted request runs
// through the sequencer before its result is loaded into the output register:
// 16 products, each a multiply state and a write-back state on the one shared
// multiplier, two gain divisions on the restoring divider, and an add/saturate
// step for the predicted state. A division whose denominator or noise is zero
// skips the iterations for that axis. The next request is taken the cycle
// after a result is loaded, so a new request may arrive while est still holds
// the previous one. If the receiver stalls, a finished result waits in the core
// until the output register frees up, and no further request is accepted.
// Reset (rst, synchronous) clears the state estimates and variances to zero,
// returns the registers to their defaults and drops est.valid. Registers must
// be written over APB only while the block is idle; the block itself does not
// enforce this. pready is tied high.
module kalman_filter_pos_vel_2state_top (
  input  logic                              clk,
  input  logic                              rst,
  kfpv_meas_if.sink                         meas,
  kfpv_est_if.source                        est,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [kfpv_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [kfpv_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [kfpv_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  kfpv_pkg::kfpv_cfg_t    cfg;
  kfpv_pkg::kfpv_result_t res;
  kfpv_pkg::kfpv_result_t res_q;
  logic                   res_load;
  logic                   res_free;
  logic                   est_valid;

  kfpv_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  kfpv_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .meas     (meas),
    .res_free (res_free),
    .res_load (res_load),
    .res      (res)
  );

  assign res_free = !est_valid || est.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      est_valid <= 1'b0;
    end else if (res_load) begin
      est_valid <= 1'b1;
    end else if (est.ready) begin
      est_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_q <= res;
    end
  end

  assign est.valid         = est_valid;
  assign est.est_position  = $signed(res_q.est_position);
  assign est.est_velocity  = $signed(res_q.est_velocity);
  assign est.position_var  = res_q.position_var;
  assign est.velocity_var  = res_q.velocity_var;
  assign est.position_gain = res_q.position_gain;
  assign est.velocity_gain = res_q.velocity_gain;
  assign est.saturated     = res_q.saturated;

  // a result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_load |-> (!est.valid || est.ready))
    else $error("result loaded over a pending result");

  // the core goes busy right after taking a request
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (meas.valid && meas.ready) |=> !meas.ready)
    else $error("request accepted while core busy");

  // gains never exceed one
  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    est.valid |-> (est.position_gain <= kfpv_pkg::ONE && est.velocity_gain <= kfpv_pkg::ONE))
    else $error("gain above one");

endmodule
